### rtl/core/lsbb_pkg.sv
// Shared types and constants for the D2Q9 streaming and bounce-back block.
// Depends on nothing; every other file in rtl/core refers to it by scoped names.
package lsbb_pkg;

    localparam int NDIR   = 9;
    localparam int WORD_W = 64;
    localparam int ENT_W  = WORD_W + 1;

    localparam int MAX_INNER_DEF = 256;
    localparam int MAX_OUTER_DEF = 4096;

    localparam int CFG_AW = 4;

    localparam logic [1:0] REG_INNER = 2'd0;
    localparam logic [1:0] REG_OUTER = 2'd1;
    localparam logic [1:0] REG_DX    = 2'd2;
    localparam logic [1:0] REG_DY    = 2'd3;

    localparam logic [8:0]  INNER_RST = 9'd256;
    localparam logic [12:0] OUTER_RST = 13'd256;
    localparam logic [17:0] DX_RST    = 18'd128196;
    localparam logic [17:0] DY_RST    = 18'd251664;

    localparam logic [1:0] OFS_ZERO  = 2'd0;
    localparam logic [1:0] OFS_PLUS1 = 2'd1;
    localparam logic [1:0] OFS_MINUS2 = 2'd2;
    localparam logic [1:0] OFS_MINUS1 = 2'd3;

    localparam logic [3:0] OPP [NDIR] = '{4'd0, 4'd3, 4'd4, 4'd1, 4'd2,
                                          4'd7, 4'd8, 4'd5, 4'd6};

    typedef struct packed {
        logic              op;
        logic              solid;
        logic [WORD_W-1:0] fin0;
        logic [WORD_W-1:0] fin1;
        logic [WORD_W-1:0] fin2;
        logic [WORD_W-1:0] fin3;
        logic [WORD_W-1:0] fin4;
        logic [WORD_W-1:0] fin5;
        logic [WORD_W-1:0] fin6;
        logic [WORD_W-1:0] fin7;
        logic [WORD_W-1:0] fin8;
    } t_in;

    typedef struct packed {
        logic [WORD_W-1:0] fout0;
        logic [WORD_W-1:0] fout1;
        logic [WORD_W-1:0] fout2;
        logic [WORD_W-1:0] fout3;
        logic [WORD_W-1:0] fout4;
        logic [WORD_W-1:0] fout5;
        logic [WORD_W-1:0] fout6;
        logic [WORD_W-1:0] fout7;
        logic [WORD_W-1:0] fout8;
        logic              last_node;
    } t_out;

    typedef logic [NDIR-1:0][ENT_W-1:0] t_lane_ent;

endpackage

### rtl/core/lsbb_lane.sv
// One direction lane: ring memory of {solid, word} entries, source address and
// domain check for its offset, and registered reads. Depends on lsbb_pkg.
module lsbb_lane #(
    parameter int MAX_INNER = lsbb_pkg::MAX_INNER_DEF,
    parameter int MAX_OUTER = lsbb_pkg::MAX_OUTER_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_we,
    input  logic [$clog2(2*MAX_INNER+4)-1:0]    i_waddr,
    input  logic [lsbb_pkg::ENT_W-1:0]          i_wdata,
    input  logic                                i_en,
    input  logic [$clog2(2*MAX_INNER+4)-1:0]    i_base,
    input  logic [$clog2(2*MAX_INNER+5)-1:0]    i_pend,
    input  logic [$clog2(MAX_INNER+1)-1:0]      i_n,
    input  logic [$clog2(MAX_OUTER+1)-1:0]      i_m,
    input  logic [$clog2(MAX_OUTER)-1:0]        i_ei,
    input  logic [$clog2(MAX_INNER)-1:0]        i_ej,
    input  logic [1:0]                          i_dx,
    input  logic [1:0]                          i_dy,
    output logic [lsbb_pkg::ENT_W-1:0]          o_src,
    output logic [lsbb_pkg::ENT_W-1:0]          o_base,
    output logic                                o_src_ok
);
    localparam int RING = 2*MAX_INNER + 4;
    localparam int AW   = $clog2(RING);
    localparam int PW   = $clog2(RING + 1);
    localparam int IW   = $clog2(MAX_OUTER);
    localparam int JW   = $clog2(MAX_INNER);
    localparam int SW   = PW + 2;
    localparam int TW   = ((IW > JW) ? IW : JW) + 3;

    logic [lsbb_pkg::ENT_W-1:0] mem [RING];

    logic signed [SW-1:0] n_s, pend_s, delta, dxn, dy_s, slot;
    logic signed [TW-1:0] si, sj;
    logic [AW-1:0]        raddr;
    logic                 held, in_dom;

    logic [lsbb_pkg::ENT_W-1:0] r_src_raw, r_base, r_wd;
    logic                       r_byp, r_ok;

    always_comb begin
        n_s    = SW'(signed'({1'b0, i_n}));
        pend_s = SW'(signed'({1'b0, i_pend}));
        case (i_dx)
            lsbb_pkg::OFS_ZERO:   dxn = '0;
            lsbb_pkg::OFS_PLUS1:  dxn = -n_s;
            lsbb_pkg::OFS_MINUS2: dxn = n_s <<< 1;
            lsbb_pkg::OFS_MINUS1: dxn = n_s;
            default:              dxn = '0;
        endcase
        dy_s  = SW'(signed'(i_dy));
        delta = dxn - dy_s;
        held  = (delta <= pend_s - SW'(1)) && (-delta <= SW'(RING) - pend_s);
        slot  = SW'(signed'({1'b0, i_base})) + delta;
        if (slot < 0) begin
            slot = slot + SW'(RING);
        end else if (slot >= SW'(RING)) begin
            slot = slot - SW'(RING);
        end
        raddr  = slot[AW-1:0];
        si     = TW'(signed'({1'b0, i_ei})) - TW'(signed'(i_dx));
        sj     = TW'(signed'({1'b0, i_ej})) - TW'(signed'(i_dy));
        in_dom = (si >= 0) && (si < TW'(signed'({1'b0, i_m})))
              && (sj >= 0) && (sj < TW'(signed'({1'b0, i_n})));
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // The base node is never the one written in the same transaction, so only
    // the source read needs a bypass around the write.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_src_raw <= mem[raddr];
            r_base    <= mem[i_base];
            r_wd      <= i_wdata;
            r_byp     <= i_we && (i_waddr == raddr);
            r_ok      <= held && in_dom;
        end
    end

    assign o_src    = r_byp ? r_wd : r_src_raw;
    assign o_base   = r_base;
    assign o_src_ok = r_ok;

endmodule

### rtl/core/lsbb_merge.sv
// Merge stage: combines the lane reads into the streamed node with bounce-back
// and holds it in the output register. Depends on lsbb_pkg.
module lsbb_merge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_v1,
    input  lsbb_pkg::t_lane_ent i_src,
    input  lsbb_pkg::t_lane_ent i_base,
    input  logic [lsbb_pkg::NDIR-1:0] i_ok,
    input  logic                i_last,
    input  logic                i_stall,
    output logic                o_adv,
    output logic                o_valid,
    output lsbb_pkg::t_out      o_data
);
    logic [lsbb_pkg::NDIR-1:0][lsbb_pkg::WORD_W-1:0] v;
    logic           base_solid;
    logic           r_valid;
    lsbb_pkg::t_out r_data, n_data;

    always_comb begin
        base_solid = i_base[0][lsbb_pkg::WORD_W];
        for (int k = 0; k < lsbb_pkg::NDIR; k++) begin
            if (base_solid || !i_ok[k]) begin
                v[k] = '0;
            end else if (i_src[k][lsbb_pkg::WORD_W]) begin
                v[k] = i_base[lsbb_pkg::OPP[k]][lsbb_pkg::WORD_W-1:0];
            end else begin
                v[k] = i_src[k][lsbb_pkg::WORD_W-1:0];
            end
        end
        n_data = '{fout0: v[0], fout1: v[1], fout2: v[2], fout3: v[3], fout4: v[4],
                   fout5: v[5], fout6: v[6], fout7: v[7], fout8: v[8],
                   last_node: i_last};
    end

    assign o_adv = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_adv) begin
            r_valid <= i_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_v1) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

### rtl/core/lattice_streaming_bounce_back.sv
// D2Q9 streaming with bounce-back: takes one grid node per transaction in raster
// order and returns each streamed node one row plus one node later; drain
// transactions flush the pending nodes. Throughput is one transaction per cycle
// while no stall is raised; a transaction that yields a result has it registered in
// the lane read registers and then in the output register, and a stalled output backs
// up into the input stall. Nine direction lanes each own a ring memory with one write
// and two read ports, so all neighbors are read at once. A write to either count
// register stalls input while a shift-subtract divider re-derives the emit row and
// column from the linear emit position. No clearing pass is needed after reset.
// Depends on lsbb_pkg, lsbb_lane, lsbb_merge.
module lattice_streaming_bounce_back #(
    parameter int MAX_INNER = lsbb_pkg::MAX_INNER_DEF,
    parameter int MAX_OUTER = lsbb_pkg::MAX_OUTER_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  lsbb_pkg::t_in               i_data,
    output logic                        o_stall,
    output logic                        o_valid,
    output lsbb_pkg::t_out              o_data,
    input  logic                        i_stall,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lsbb_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    localparam int RING = 2*MAX_INNER + 4;
    localparam int AW   = $clog2(RING);
    localparam int PW   = $clog2(RING + 1);
    localparam int NW   = $clog2(MAX_INNER + 1);
    localparam int MW   = $clog2(MAX_OUTER + 1);
    localparam int IW   = $clog2(MAX_OUTER);
    localparam int JW   = $clog2(MAX_INNER);
    localparam int EW   = NW + IW;
    localparam int TOTW = NW + MW;
    localparam int SCW  = $clog2(IW);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV
    } t_div_state;

    logic [8:0]  r_inner_cnt;
    logic [12:0] r_outer_cnt;
    logic [17:0] r_dx, r_dy;

    logic [NW-1:0] eff_n;
    logic [MW-1:0] eff_m;

    logic [AW-1:0] r_head, n_head, base;
    logic [PW-1:0] r_pend, pend_inc;
    logic [IW-1:0] r_ei;
    logic [JW-1:0] r_ej;
    logic          r_v1, r_last1;
    logic          accept, emit, adv_o, adv_1, last_now;
    logic [lsbb_pkg::ENT_W-1:0] wdata [lsbb_pkg::NDIR];

    lsbb_pkg::t_lane_ent        src_ent, base_ent;
    logic [lsbb_pkg::NDIR-1:0]  src_ok;

    t_div_state      r_state;
    logic [EW-1:0]   r_epos, r_rem, r_dsr, div_rem;
    logic            r_ezero, div_bit, epos_over, cnt_wr;
    logic [IW-1:0]   r_q, div_q;
    logic [SCW-1:0]  r_step;
    logic [TOTW-1:0] total;

    // Configuration port.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner_cnt <= lsbb_pkg::INNER_RST;
            r_outer_cnt <= lsbb_pkg::OUTER_RST;
            r_dx        <= lsbb_pkg::DX_RST;
            r_dy        <= lsbb_pkg::DY_RST;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                lsbb_pkg::REG_INNER: r_inner_cnt <= pwdata[8:0];
                lsbb_pkg::REG_OUTER: r_outer_cnt <= pwdata[12:0];
                lsbb_pkg::REG_DX:    r_dx        <= pwdata[17:0];
                lsbb_pkg::REG_DY:    r_dy        <= pwdata[17:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            lsbb_pkg::REG_INNER: prdata = {23'd0, r_inner_cnt};
            lsbb_pkg::REG_OUTER: prdata = {19'd0, r_outer_cnt};
            lsbb_pkg::REG_DX:    prdata = {14'd0, r_dx};
            lsbb_pkg::REG_DY:    prdata = {14'd0, r_dy};
            default:             prdata = '0;
        endcase
    end

    // Counts are used clamped to 1..MAX.
    always_comb begin
        if (r_inner_cnt == '0) begin
            eff_n = NW'(1);
        end else if (32'(r_inner_cnt) > MAX_INNER) begin
            eff_n = NW'(MAX_INNER);
        end else begin
            eff_n = NW'(r_inner_cnt);
        end
        if (r_outer_cnt == '0) begin
            eff_m = MW'(1);
        end else if (32'(r_outer_cnt) > MAX_OUTER) begin
            eff_m = MW'(MAX_OUTER);
        end else begin
            eff_m = MW'(r_outer_cnt);
        end
    end

    // A count change moves the geometry under the linear emit position, so the
    // emit row and column are rebuilt by dividing that position by the row length.
    assign cnt_wr = psel && penable && pwrite
                 && ((paddr[3:2] == lsbb_pkg::REG_INNER)
                  || (paddr[3:2] == lsbb_pkg::REG_OUTER));
    assign total     = TOTW'(eff_n) * TOTW'(eff_m);
    assign epos_over = TOTW'(r_epos) >= total;

    always_comb begin
        div_bit = r_rem >= r_dsr;
        div_rem = div_bit ? r_rem - r_dsr : r_rem;
        div_q   = {r_q[IW-2:0], div_bit};
    end

    // Pipeline control: lane read registers, then the output register.
    assign adv_1   = !r_v1 || adv_o;
    assign o_stall = !adv_1 || cnt_wr || (r_state != ST_IDLE);
    assign accept  = i_valid && !o_stall;

    always_comb begin
        if (i_data.op) begin
            n_head   = r_head;
            pend_inc = r_pend;
            emit     = accept && (r_pend != '0);
        end else begin
            n_head   = (32'(r_head) == RING - 1) ? '0 : r_head + AW'(1);
            pend_inc = (32'(r_pend) == RING) ? r_pend : r_pend + PW'(1);
            emit     = accept && ((PW+1)'(pend_inc) > (PW+1)'(eff_n) + (PW+1)'(1));
        end
        // Oldest pending node sits pend_inc entries behind the head.
        if ((AW+1)'(n_head) >= (AW+1)'(pend_inc)) begin
            base = AW'((AW+1)'(n_head) - (AW+1)'(pend_inc));
        end else begin
            base = AW'((AW+1)'(n_head) + (AW+1)'(RING) - (AW+1)'(pend_inc));
        end
        last_now = ((MW+1)'(r_ei) == (MW+1)'(eff_m) - (MW+1)'(1))
                && ((NW+1)'(r_ej) == (NW+1)'(eff_n) - (NW+1)'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_pend  <= '0;
            r_ei    <= '0;
            r_ej    <= '0;
            r_v1    <= 1'b0;
            r_epos  <= '0;
            r_ezero <= 1'b0;
            r_state <= ST_IDLE;
            r_rem   <= '0;
            r_dsr   <= '0;
            r_q     <= '0;
            r_step  <= '0;
        end else begin
            if (adv_1) begin
                r_v1 <= emit;
            end
            if (accept) begin
                r_head <= n_head;
                r_pend <= emit ? pend_inc - PW'(1) : pend_inc;
            end
            if (cnt_wr) begin
                r_state <= ST_LOAD;
            end else begin
                case (r_state)
                    ST_IDLE: ;
                    ST_LOAD: begin
                        // A position past the end of the new grid restarts at zero.
                        r_ezero <= epos_over;
                        r_rem   <= epos_over ? '0 : r_epos;
                        r_dsr   <= EW'(eff_n) << (IW-1);
                        r_q     <= '0;
                        r_step  <= SCW'(IW-1);
                        r_state <= ST_DIV;
                    end
                    ST_DIV: begin
                        r_rem  <= div_rem;
                        r_dsr  <= r_dsr >> 1;
                        r_q    <= div_q;
                        r_step <= r_step - SCW'(1);
                        if (r_step == '0) begin
                            r_ei    <= div_q;
                            r_ej    <= JW'(div_rem);
                            r_state <= ST_IDLE;
                        end
                    end
                    default: r_state <= ST_IDLE;
                endcase
            end
            if (emit) begin
                r_ezero <= 1'b0;
                if (last_now) begin
                    r_epos <= '0;
                end else if (r_ezero) begin
                    r_epos <= EW'(1);
                end else begin
                    r_epos <= r_epos + EW'(1);
                end
                if ((NW+1)'(r_ej) + (NW+1)'(1) >= (NW+1)'(eff_n)) begin
                    r_ej <= '0;
                    if ((MW+1)'(r_ei) + (MW+1)'(1) >= (MW+1)'(eff_m)) begin
                        r_ei <= '0;
                    end else begin
                        r_ei <= r_ei + IW'(1);
                    end
                end else begin
                    r_ej <= r_ej + JW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_1) begin
            r_last1 <= last_now;
        end
    end

    assign wdata[0] = {i_data.solid, i_data.fin0};
    assign wdata[1] = {i_data.solid, i_data.fin1};
    assign wdata[2] = {i_data.solid, i_data.fin2};
    assign wdata[3] = {i_data.solid, i_data.fin3};
    assign wdata[4] = {i_data.solid, i_data.fin4};
    assign wdata[5] = {i_data.solid, i_data.fin5};
    assign wdata[6] = {i_data.solid, i_data.fin6};
    assign wdata[7] = {i_data.solid, i_data.fin7};
    assign wdata[8] = {i_data.solid, i_data.fin8};

    for (genvar k = 0; k < lsbb_pkg::NDIR; k++) begin : g_lane
        lsbb_lane #(
            .MAX_INNER(MAX_INNER),
            .MAX_OUTER(MAX_OUTER)
        ) u_lane (
            .i_clk   (i_clk),
            .i_we    (accept && !i_data.op),
            .i_waddr (r_head),
            .i_wdata (wdata[k]),
            .i_en    (adv_1),
            .i_base  (base),
            .i_pend  (pend_inc),
            .i_n     (eff_n),
            .i_m     (eff_m),
            .i_ei    (r_ei),
            .i_ej    (r_ej),
            .i_dx    (r_dx[2*k +: 2]),
            .i_dy    (r_dy[2*k +: 2]),
            .o_src   (src_ent[k]),
            .o_base  (base_ent[k]),
            .o_src_ok(src_ok[k])
        );
    end

    lsbb_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_v1    (r_v1),
        .i_src   (src_ent),
        .i_base  (base_ent),
        .i_ok    (src_ok),
        .i_last  (r_last1),
        .i_stall (i_stall),
        .o_adv   (adv_o),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

endmodule

### bench/tb_lattice_streaming_bounce_back.sv
// Testbench for lattice_streaming_bounce_back: random and directed grid streams
// checked against a behavioral streaming/bounce-back predictor in a scoreboard class.
// Depends on lsbb_pkg and the block's RTL.
module tb_lattice_streaming_bounce_back;

    localparam int LINE_INNER = 256;
    localparam int LINE_OUTER = 4096;
    localparam int RING_DEPTH = 2 * LINE_INNER + 4;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic OP_NODE  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    class stream_scoreboard;
        logic [8:0]  inner_cfg = lsbb_pkg::INNER_RST;
        logic [12:0] outer_cfg = lsbb_pkg::OUTER_RST;
        logic [17:0] dx_cfg = lsbb_pkg::DX_RST;
        logic [17:0] dy_cfg = lsbb_pkg::DY_RST;
        logic [63:0] words [RING_DEPTH][lsbb_pkg::NDIR];
        bit          solids [RING_DEPTH];
        int          head, pending, emit_idx;
        lsbb_pkg::t_out expected_q [$];
        int          errors, checked;

        function new();
            foreach (solids[r]) begin
                solids[r] = 0;
                for (int k = 0; k < lsbb_pkg::NDIR; k++) words[r][k] = '0;
            end
        endfunction

        function int rows_n();
            if (inner_cfg < 1) return 1;
            if (inner_cfg > LINE_INNER) return LINE_INNER;
            return int'(inner_cfg);
        endfunction

        function int rows_m();
            if (outer_cfg < 1) return 1;
            if (outer_cfg > LINE_OUTER) return LINE_OUTER;
            return int'(outer_cfg);
        endfunction

        function int offset(logic [17:0] codes, int k);
            logic [1:0] c;
            c = codes[2*k +: 2];
            return $signed(c);
        endfunction

        function void stream_node();
            int n, m, total, i, j, base, dx, dy, si, sj, delta, slot;
            bit in_dom, held;
            lsbb_pkg::t_out r;
            logic [63:0] v [lsbb_pkg::NDIR];
            n = rows_n();
            m = rows_m();
            total = n * m;
            if (emit_idx >= total) emit_idx = 0;
            i = emit_idx / n;
            j = emit_idx % n;
            base = (head + RING_DEPTH - (pending % RING_DEPTH)) % RING_DEPTH;
            for (int k = 0; k < lsbb_pkg::NDIR; k++) begin
                v[k] = '0;
                if (!solids[base]) begin
                    dx = offset(dx_cfg, k);
                    dy = offset(dy_cfg, k);
                    si = i - dx;
                    sj = j - dy;
                    delta = -dx * n - dy;
                    in_dom = si >= 0 && si < m && sj >= 0 && sj < n;
                    held = delta <= pending - 1 && -delta <= RING_DEPTH - pending;
                    if (in_dom && held) begin
                        slot = (base + RING_DEPTH + delta) % RING_DEPTH;
                        // A solid source reflects the node's own opposite word.
                        if (solids[slot]) v[k] = words[base][lsbb_pkg::OPP[k]];
                        else v[k] = words[slot][k];
                    end
                end
            end
            r = '{v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8],
                  emit_idx == total - 1};
            expected_q.push_back(r);
            emit_idx = (emit_idx + 1 >= total) ? 0 : emit_idx + 1;
            pending--;
        endfunction

        function void note_input(lsbb_pkg::t_in t);
            if (t.op == OP_DRAIN) begin
                if (pending != 0) stream_node();
                return;
            end
            words[head] = '{t.fin0, t.fin1, t.fin2, t.fin3, t.fin4,
                            t.fin5, t.fin6, t.fin7, t.fin8};
            solids[head] = t.solid;
            head = (head + 1) % RING_DEPTH;
            if (pending < RING_DEPTH) pending++;
            if (pending > rows_n() + 1) stream_node();
        endfunction

        function void check_result(lsbb_pkg::t_out got);
            lsbb_pkg::t_out e;
            if (expected_q.size() == 0) begin
                report_mismatch("result with nothing expected", '0, '0);
                return;
            end
            e = expected_q.pop_front();
            checked++;
            for (int k = 0; k < lsbb_pkg::NDIR; k++)
                if (got[64*(lsbb_pkg::NDIR-k) -: 64] !== e[64*(lsbb_pkg::NDIR-k) -: 64])
                    report_mismatch($sformatf("fout%0d", k),
                                    got[64*(lsbb_pkg::NDIR-k) -: 64],
                                    e[64*(lsbb_pkg::NDIR-k) -: 64]);
            if (got.last_node !== e.last_node)
                report_mismatch("last_node", 64'(got.last_node), 64'(e.last_node));
        endfunction

        function void report_mismatch(string what, logic [63:0] got, logic [63:0] exp_v);
            errors++;
            if (errors <= 40)
                $display("mismatch %s: got %h expected %h (result %0d)",
                         what, got, exp_v, checked);
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0;
    logic i_valid = 0, i_stall = 0;
    lsbb_pkg::t_in  i_data = '0;
    logic o_stall, o_valid, pready;
    lsbb_pkg::t_out o_data;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [lsbb_pkg::CFG_AW-1:0] paddr = '0;
    logic [31:0] pwdata = '0, prdata;

    stream_scoreboard sb = new();
    int idle_pct = 34;
    bit hold_off = 0;
    int idle_cycles, accepted_in, accepted_out, cfg_writes;

    lattice_streaming_bounce_back u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_data(i_data),
        .o_stall(o_stall), .o_valid(o_valid), .o_data(o_data), .i_stall(i_stall),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #2 i_clk = ~i_clk;

    // Receiver side: random stall, and a long hold-off when requested.
    always @(posedge i_clk) begin
        if (o_valid && !i_stall && i_rst_n) begin
            sb.check_result(o_data);
            accepted_out++;
        end
        i_stall <= hold_off || ($urandom_range(99) < idle_pct);
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", idle_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= lsbb_pkg::CFG_AW'(4 * idx); pwdata <= value;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            lsbb_pkg::REG_INNER: sb.inner_cfg = value[8:0];
            lsbb_pkg::REG_OUTER: sb.outer_cfg = value[12:0];
            lsbb_pkg::REG_DX:    sb.dx_cfg = value[17:0];
            lsbb_pkg::REG_DY:    sb.dy_cfg = value[17:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    // Offers one transaction, holding it until the block takes it. Valid stays
    // high after acceptance until the caller offers the next one or idles.
    task automatic send(lsbb_pkg::t_in t);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_data <= t;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_input(t);
        accepted_in++;
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom_range(3))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic lsbb_pkg::t_in rand_node(int solid_pct);
        lsbb_pkg::t_in t;
        t.op = OP_NODE;
        t.solid = $urandom_range(99) < solid_pct;
        {t.fin0, t.fin1, t.fin2} = {rand_word(), rand_word(), rand_word()};
        {t.fin3, t.fin4, t.fin5} = {rand_word(), rand_word(), rand_word()};
        {t.fin6, t.fin7, t.fin8} = {rand_word(), rand_word(), rand_word()};
        return t;
    endfunction

    // Sends one complete grid, then drains it so the block ends empty.
    task automatic run_grid(int solid_pct);
        lsbb_pkg::t_in d;
        int nodes;
        d = '0;
        d.op = OP_DRAIN;
        nodes = sb.rows_n() * sb.rows_m();
        for (int q = 0; q < nodes; q++) send(rand_node(solid_pct));
        while (sb.pending > 0) send(d);
    endtask

    task automatic settle();
        i_valid <= 0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_grid(int n, int m, logic [17:0] dx, logic [17:0] dy);
        settle();
        write_reg(lsbb_pkg::REG_INNER, n);
        write_reg(lsbb_pkg::REG_OUTER, m);
        write_reg(lsbb_pkg::REG_DX, 32'(dx));
        write_reg(lsbb_pkg::REG_DY, 32'(dy));
    endtask

    initial begin
        lsbb_pkg::t_in d;
        d = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: drain on empty, small grid, all-fluid and all-solid nodes,
        // extreme words, offsets of -2.
        set_grid(3, 3, lsbb_pkg::DX_RST, lsbb_pkg::DY_RST);
        d.op = OP_DRAIN;
        d.solid = 1;
        d.fin0 = '1;
        send(d);
        d = rand_node(0);
        d.fin0 = '1; d.fin8 = '0;
        send(d);
        d.solid = 1;
        send(d);
        for (int q = 0; q < 7; q++) send(rand_node(30));
        d = '0;
        d.op = OP_DRAIN;
        while (sb.pending > 0) send(d);
        set_grid(3, 3, 18'h2AAAA, 18'h15555);
        run_grid(20);

        // Random: well-formed grids with varied geometry and offsets.
        while (accepted_in < 450) begin
            case ($urandom_range(5))
                0: set_grid(3, $urandom_range(3, 6), 18'($urandom), 18'($urandom));
                1: set_grid($urandom_range(3, 8), 3, lsbb_pkg::DX_RST, lsbb_pkg::DY_RST);
                2: set_grid($urandom_range(3, 12), $urandom_range(3, 5),
                            18'($urandom), 18'($urandom));
                3: set_grid(4, 4, lsbb_pkg::DX_RST, lsbb_pkg::DY_RST);
                default: set_grid($urandom_range(3, 6), $urandom_range(3, 6),
                                  18'($urandom), 18'($urandom));
            endcase
            idle_pct = ($urandom_range(3) == 0) ? 0 : 34;
            // When none is running, hold the receiver off long enough for the block to stall input.
            if (accepted_in > 200 && cfg_writes < 200 && !hold_off && accepted_out > 0) begin
                fork
                    begin
                        hold_off = 1;
                        repeat (300) @(posedge i_clk);
                        hold_off = 0;
                    end
                join_none
            end
            run_grid($urandom_range(60));
        end

        // Extremes with no idling: widest row, stopped part way through the grid.
        idle_pct = 0;
        set_grid(256, 3, lsbb_pkg::DX_RST, lsbb_pkg::DY_RST);
        for (int q = 0; q < 270; q++) send(rand_node(10));
        d = '0;
        d.op = OP_DRAIN;
        while (sb.pending > 0) send(d);

        // Geometry changed with the emit position in mid-grid: a tall narrow grid,
        // then the reset counts again.
        idle_pct = 34;
        set_grid(3, 4096, lsbb_pkg::DX_RST, lsbb_pkg::DY_RST);
        for (int q = 0; q < 20; q++) send(rand_node(20));
        while (sb.pending > 0) send(d);
        set_grid(lsbb_pkg::INNER_RST, lsbb_pkg::OUTER_RST, 18'h3FFFF, 18'h0);
        for (int q = 0; q < 100; q++) send(rand_node(10));
        while (sb.pending > 0) send(d);
        settle();

        $display("Streamed %0d transactions in, %0d nodes out, over %0d register writes.",
                 accepted_in, accepted_out, cfg_writes);
        $display("Covered small and widest grids, mid-grid geometry changes and stalls.");
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule

### files.f
rtl/core/lsbb_pkg.sv
rtl/core/lsbb_lane.sv
rtl/core/lsbb_merge.sv
rtl/core/lattice_streaming_bounce_back.sv
bench/tb_lattice_streaming_bounce_back.sv
